// ===== sv/scfd_pkg.sv =====
`timescale 1ns / 1ps

package scfd_pkg;

  // Bit p of each mask is the coil level at half-step phase p.
  localparam logic [7:0] COIL_A_MASK = 8'h83;
  localparam logic [7:0] COIL_B_MASK = 8'h38;
  localparam logic [7:0] COIL_C_MASK = 8'h0E;
  localparam logic [7:0] COIL_D_MASK = 8'hE0;

  localparam logic [7:0] MARKER_RESET   = 8'hFF;
  localparam logic [7:0] MOTOR_STEPPER  = 8'd1;
  localparam logic [7:0] MODE_SINGLE    = 8'd0;
  localparam logic [7:0] MODE_CONTINUOUS = 8'd1;
  localparam logic [7:0] DIR_UP         = 8'd0;
  localparam logic [7:0] DIR_DOWN       = 8'd1;

  localparam logic [2:0] PHASE_FIRST = 3'd0;
  localparam logic [2:0] PHASE_FINAL = 3'd7;

  // Command decoded on the closing byte of a frame.
  typedef struct packed {
    logic run;     // start an eight-phase run
    logic up;      // phases count 0..7, else 7..0
    logic toggle;  // flip the indicator before the run
  } cmd_t;

  // {a, b, c, d} coil levels for one phase.
  function automatic logic [3:0] coil_pattern(logic [2:0] phase);
    coil_pattern = {COIL_A_MASK[phase], COIL_B_MASK[phase],
                    COIL_C_MASK[phase], COIL_D_MASK[phase]};
  endfunction

endpackage

// ===== sv/scfd_if.sv =====
`timescale 1ns / 1ps

interface scfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface scfd_phase_if;
  logic       valid;
  logic       ready;
  logic       coil_a;
  logic       coil_b;
  logic       coil_c;
  logic       coil_d;
  logic [2:0] phase_index;
  logic       indicator;
  logic       last;

  modport source (output valid, output coil_a, output coil_b, output coil_c,
                  output coil_d, output phase_index, output indicator,
                  output last, input ready);
  modport sink (input valid, input coil_a, input coil_b, input coil_c,
                input coil_d, input phase_index, input indicator,
                input last, output ready);
endinterface

// ===== sv/stepper_command_frame_driver.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Payload                                         Handshake
// rx_i      in   rx_byte[7:0]                                    valid/ready
// phase_o   out  coil_a..coil_d, phase_index[2:0], indicator,    valid/ready
//                last
// cfg       in   start_marker_i[7:0]                             start_marker_we_i
//
// One byte is taken per cycle while rx_i.ready is high. The closing byte of a
// stepper command loads the output register, and the first phase is presented
// in the next cycle. The eight phase transactions then leave one per cycle
// while phase_o.ready is high. The closing byte of the next frame is held off
// (rx_i.ready low) until the run has drained and the output reads idle. Reset
// clears the frame position, indicator and output valid; the start marker
// resets to 8'hFF.
module stepper_command_frame_driver
  import scfd_pkg::*;
#(
  parameter int FRAME_BYTES = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_marker_we_i,
  input  logic [7:0] start_marker_i,
  scfd_rx_if.sink    rx_i,
  scfd_phase_if.source phase_o
);

  cmd_t       cmd;
  logic       out_valid_q;
  logic       up_q;
  logic       last_q;
  logic       ind_q;
  logic [2:0] phase_q;
  logic [3:0] coils_q;
  logic [2:0] phase_next;

  scfd_frame_parser #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_marker_we_i(start_marker_we_i),
    .start_marker_i   (start_marker_i),
    .valid_i          (rx_i.valid),
    .rx_byte_i        (rx_i.rx_byte),
    .busy_i           (out_valid_q),
    .ready_o          (rx_i.ready),
    .cmd_o            (cmd)
  );

  assign phase_next = up_q ? phase_q + 3'd1 : phase_q - 3'd1;

  // A new run only starts when the output is idle, so load and advance
  // never coincide.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      ind_q       <= 1'b0;
      up_q        <= 1'b1;
      last_q      <= 1'b0;
      phase_q     <= PHASE_FIRST;
      coils_q     <= coil_pattern(PHASE_FIRST);
    end else begin
      if (cmd.run) begin
        out_valid_q <= 1'b1;
        up_q        <= cmd.up;
        last_q      <= 1'b0;
        ind_q       <= ind_q ^ cmd.toggle;
        phase_q     <= cmd.up ? PHASE_FIRST : PHASE_FINAL;
        coils_q     <= coil_pattern(cmd.up ? PHASE_FIRST : PHASE_FINAL);
      end else if (out_valid_q && phase_o.ready) begin
        if (last_q) begin
          out_valid_q <= 1'b0;
        end else begin
          phase_q <= phase_next;
          coils_q <= coil_pattern(phase_next);
          last_q  <= up_q ? (phase_next == PHASE_FINAL) : (phase_next == PHASE_FIRST);
        end
      end
    end
  end

  assign phase_o.valid       = out_valid_q;
  assign phase_o.coil_a      = coils_q[3];
  assign phase_o.coil_b      = coils_q[2];
  assign phase_o.coil_c      = coils_q[1];
  assign phase_o.coil_d      = coils_q[0];
  assign phase_o.phase_index = phase_q;
  assign phase_o.indicator   = ind_q;
  assign phase_o.last        = last_q;

endmodule

// ===== sv/scfd_frame_parser.sv =====
`timescale 1ns / 1ps

module scfd_frame_parser
  import scfd_pkg::*;
#(
  parameter int FRAME_BYTES = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_marker_we_i,
  input  logic [7:0] start_marker_i,
  input  logic       valid_i,
  input  logic [7:0] rx_byte_i,
  input  logic       busy_i,
  output logic       ready_o,
  output cmd_t       cmd_o
);

  localparam int POS_W = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  logic [7:0]       marker_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             motor_ok_q, motor_ok_d;
  logic             mode_single_q, mode_single_d;
  logic             mode_cont_q, mode_cont_d;
  logic             dir_up_q, dir_up_d;
  logic             dir_down_q, dir_down_d;
  logic             accept;
  logic             closing;

  // The closing byte waits while a previous run is still draining.
  assign closing = (pos_q == LAST_POS);
  assign ready_o = !(closing && busy_i);
  assign accept  = valid_i && ready_o;

  always_comb begin
    pos_d         = pos_q;
    motor_ok_d    = motor_ok_q;
    mode_single_d = mode_single_q;
    mode_cont_d   = mode_cont_q;
    dir_up_d      = dir_up_q;
    dir_down_d    = dir_down_q;
    if (accept) begin
      if (pos_q == '0) begin
        if (rx_byte_i == marker_q) begin
          pos_d = POS_W'(1);
        end
      end else begin
        if (pos_q == POS_W'(1)) begin
          motor_ok_d = (rx_byte_i == MOTOR_STEPPER);
        end
        if (pos_q == POS_W'(2)) begin
          mode_single_d = (rx_byte_i == MODE_SINGLE);
          mode_cont_d   = (rx_byte_i == MODE_CONTINUOUS);
        end
        if (pos_q == POS_W'(3)) begin
          dir_up_d   = (rx_byte_i == DIR_UP);
          dir_down_d = (rx_byte_i == DIR_DOWN);
        end
        pos_d = closing ? '0 : pos_q + POS_W'(1);
      end
    end
  end

  always_comb begin
    cmd_o.run    = accept && closing && motor_ok_q &&
                   ((mode_single_q && (dir_up_q || dir_down_q)) || mode_cont_q);
    cmd_o.up     = mode_single_q && dir_up_q;
    cmd_o.toggle = mode_cont_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q      <= MARKER_RESET;
      pos_q         <= '0;
      motor_ok_q    <= 1'b0;
      mode_single_q <= 1'b1;
      mode_cont_q   <= 1'b0;
      dir_up_q      <= 1'b1;
      dir_down_q    <= 1'b0;
    end else begin
      if (start_marker_we_i) begin
        marker_q <= start_marker_i;
      end
      pos_q         <= pos_d;
      motor_ok_q    <= motor_ok_d;
      mode_single_q <= mode_single_d;
      mode_cont_q   <= mode_cont_d;
      dir_up_q      <= dir_up_d;
      dir_down_q    <= dir_down_d;
    end
  end

endmodule

// ===== sv/scfd_checker.sv =====
`timescale 1ns / 1ps

module scfd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       ready_i,
  input logic       coil_a_i,
  input logic [2:0] phase_index_i,
  input logic       last_i
);

  logic out_fire;
  assign out_fire = valid_i && ready_i;

  // A stalled transaction holds its phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(phase_index_i))
    else $error("stalled phase transaction changed");

  // A run keeps going until its last phase, stepping by one either way.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !last_i |=> valid_i &&
      ((3'(phase_index_i - $past(phase_index_i)) == 3'd1) ||
       (3'(phase_index_i - $past(phase_index_i)) == 3'd7)))
    else $error("run broken or phase skipped");

  // A run ends on phase 0 or phase 7.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && last_i |-> phase_index_i == 3'd0 || phase_index_i == 3'd7)
    else $error("last flag on an inner phase");

  // Coil A is energized only on phases 7, 0 and 1.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> coil_a_i == (phase_index_i == 3'd0 ||
      phase_index_i == 3'd1 || phase_index_i == 3'd7))
    else $error("coil A pattern mismatch");

endmodule

bind stepper_command_frame_driver scfd_checker u_scfd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .valid_i      (phase_o.valid),
  .ready_i      (phase_o.ready),
  .coil_a_i     (phase_o.coil_a),
  .phase_index_i(phase_o.phase_index),
  .last_i       (phase_o.last)
);

// ===== tb/stepper_command_frame_driver_tb.sv =====
`timescale 1ns / 1ps

module stepper_command_frame_driver_tb;
  import scfd_pkg::*;

  localparam int FRAME_LEN   = 6;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 16;
  localparam int FRAME_GOAL  = 45;  // frame bytes per random phase
  localparam int PRINT_CAP   = 40;

  // bit p = coil level at half-step phase p
  localparam logic [7:0] COIL_A_BY_PHASE = 8'b1000_0011;
  localparam logic [7:0] COIL_B_BY_PHASE = 8'b0011_1000;
  localparam logic [7:0] COIL_C_BY_PHASE = 8'b0000_1110;
  localparam logic [7:0] COIL_D_BY_PHASE = 8'b1110_0000;

  typedef struct packed {
    logic       coil_a;
    logic       coil_b;
    logic       coil_c;
    logic       coil_d;
    logic [2:0] phase_index;
    logic       indicator;
    logic       last;
  } coil_phase_t;

  logic       clk;
  logic       rst_n;
  logic       start_marker_we;
  logic [7:0] start_marker_d;

  scfd_rx_if    rx_bus();
  scfd_phase_if phase_bus();

  stepper_command_frame_driver #(
    .FRAME_BYTES(FRAME_LEN)
  ) u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_marker_we_i(start_marker_we),
    .start_marker_i   (start_marker_d),
    .rx_i             (rx_bus),
    .phase_o          (phase_bus)
  );

  // Frame tracker state, mirrors the block after reset.
  logic [7:0]  marker_now = MARKER_RESET;
  int          frame_pos = 0;
  logic [7:0]  motor_byte = '0;
  logic [7:0]  mode_byte = '0;
  logic [7:0]  dir_byte = '0;
  logic        indicator_lvl = 1'b0;

  coil_phase_t coil_phases_due[$];
  logic [7:0]  byte_queue[$];

  int  send_idle_pct;
  int  recv_idle_pct;
  int  frame_bytes_pushed;
  int  mismatch_count = 0;
  int  stall_cycles = 0;
  logic rx_fire;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic log_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic queue_coil_run(input bit upward);
    coil_phase_t r;
    logic [2:0]  ph;
    for (int k = 0; k < 8; k++) begin
      ph            = upward ? 3'(k) : 3'(7 - k);
      r.coil_a      = COIL_A_BY_PHASE[ph];
      r.coil_b      = COIL_B_BY_PHASE[ph];
      r.coil_c      = COIL_C_BY_PHASE[ph];
      r.coil_d      = COIL_D_BY_PHASE[ph];
      r.phase_index = ph;
      r.indicator   = indicator_lvl;
      r.last        = (k == 7);
      coil_phases_due.push_back(r);
    end
  endtask

  task automatic decode_command();
    if (motor_byte == MOTOR_STEPPER) begin
      if (mode_byte == MODE_SINGLE) begin
        if (dir_byte == DIR_UP) queue_coil_run(1'b1);
        else if (dir_byte == DIR_DOWN) queue_coil_run(1'b0);
      end else if (mode_byte == MODE_CONTINUOUS) begin
        indicator_lvl = ~indicator_lvl;
        queue_coil_run(1'b0);
      end
    end
  endtask

  task automatic track_rx_byte(input logic [7:0] b);
    if (frame_pos == 0) begin
      if (b == marker_now) frame_pos = 1;
    end else begin
      case (frame_pos)
        1: motor_byte = b;
        2: mode_byte = b;
        3: dir_byte = b;
        default: ;
      endcase
      if (frame_pos + 1 >= FRAME_LEN) begin
        frame_pos = 0;
        decode_command();
      end else begin
        frame_pos++;
      end
    end
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      log_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Monitor: predicts on each rx transaction, checks each phase transaction.
  always @(posedge clk) begin
    coil_phase_t want;
    if (!rst_n) begin
      rx_fire      <= 1'b0;
      stall_cycles = 0;
    end else begin
      rx_fire <= rx_bus.valid && rx_bus.ready;
      if (rx_bus.valid && rx_bus.ready) track_rx_byte(rx_bus.rx_byte);
      if (phase_bus.valid && phase_bus.ready) begin
        if (coil_phases_due.size() == 0) begin
          log_mismatch($sformatf("unexpected phase transaction, phase %0d",
                                 phase_bus.phase_index));
        end else begin
          want = coil_phases_due.pop_front();
          check_field("coil_a", phase_bus.coil_a, want.coil_a);
          check_field("coil_b", phase_bus.coil_b, want.coil_b);
          check_field("coil_c", phase_bus.coil_c, want.coil_c);
          check_field("coil_d", phase_bus.coil_d, want.coil_d);
          check_field("phase_index", phase_bus.phase_index, want.phase_index);
          check_field("indicator", phase_bus.indicator, want.indicator);
          check_field("last", phase_bus.last, want.last);
        end
      end
      if ((rx_bus.valid && rx_bus.ready) || (phase_bus.valid && phase_bus.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("stepper_command_frame_driver_tb: errors");
        $finish;
      end
    end
  end

  // Driver: valid holds until the transaction is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      rx_bus.valid    <= 1'b0;
      phase_bus.ready <= 1'b0;
    end else begin
      if (rx_fire) void'(byte_queue.pop_front());
      if (!(rx_bus.valid && !rx_fire)) begin
        if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          rx_bus.valid   <= 1'b1;
          rx_bus.rx_byte <= byte_queue[0];
        end else begin
          rx_bus.valid <= 1'b0;
        end
      end
      phase_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_frame(input logic [7:0] motor, input logic [7:0] mode,
                            input logic [7:0] dir, input logic [7:0] d0,
                            input logic [7:0] d1);
    byte_queue.push_back(marker_now);
    byte_queue.push_back(motor);
    byte_queue.push_back(mode);
    byte_queue.push_back(dir);
    byte_queue.push_back(d0);
    byte_queue.push_back(d1);
    frame_bytes_pushed += FRAME_LEN;
  endtask

  function automatic logic [7:0] pick_code(input logic [7:0] usual_max);
    if ($urandom_range(99) < 85) return 8'($urandom_range(usual_max));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_data();
    if ($urandom_range(9) == 0) return marker_now;
    return 8'($urandom_range(255));
  endfunction

  task automatic push_random_frame();
    logic [7:0] motor;
    motor = ($urandom_range(99) < 85) ? MOTOR_STEPPER : 8'($urandom_range(255));
    push_frame(motor, pick_code(MODE_CONTINUOUS), pick_code(DIR_DOWN),
               pick_data(), pick_data());
  endtask

  task automatic fill_random_phase();
    int sel;
    int n;
    frame_bytes_pushed = 0;
    while (frame_bytes_pushed < FRAME_GOAL) begin
      sel = $urandom_range(99);
      if (sel < 12) begin
        // line noise while hunting
        n = $urandom_range(1, 3);
        repeat (n) byte_queue.push_back(8'($urandom_range(255)));
      end else if (sel < 24) begin
        // truncated frame, the next frame's bytes complete it
        byte_queue.push_back(marker_now);
        n = $urandom_range(0, FRAME_LEN - 2);
        repeat (n) byte_queue.push_back(pick_data());
        frame_bytes_pushed += n + 1;
      end
      push_random_frame();
    end
  endtask

  task automatic wait_drained();
    while (byte_queue.size() != 0 || rx_bus.valid || coil_phases_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_marker(input logic [7:0] value);
    @(negedge clk);
    start_marker_we <= 1'b1;
    start_marker_d  <= value;
    @(negedge clk);
    start_marker_we <= 1'b0;
    marker_now = value;
  endtask

  initial begin
    rst_n           = 1'b0;
    start_marker_we = 1'b0;
    start_marker_d  = MARKER_RESET;
    rx_bus.valid    = 1'b0;
    rx_bus.rx_byte  = '0;
    phase_bus.ready = 1'b0;
    send_idle_pct   = 31;
    recv_idle_pct   = 71;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: noise, up, down with marker as data, continuous, unknown mode.
    byte_queue.push_back(8'h00);
    byte_queue.push_back(8'h7E);
    push_frame(MOTOR_STEPPER, MODE_SINGLE, DIR_UP, 8'hFF, 8'h00);
    push_frame(MOTOR_STEPPER, MODE_SINGLE, DIR_DOWN, 8'h00, marker_now);
    push_frame(MOTOR_STEPPER, MODE_CONTINUOUS, 8'h05, 8'hA5, 8'h5A);
    push_frame(MOTOR_STEPPER, 8'h02, DIR_UP, 8'hFF, 8'hFF);
    fill_random_phase();
    wait_drained();

    send_idle_pct = 71;
    recv_idle_pct = 31;
    write_marker(8'h00);
    fill_random_phase();
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_marker(8'($urandom_range(1, 254)));
    fill_random_phase();
    wait_drained();

    write_marker(8'hFF);
    fill_random_phase();
    wait_drained();

    if (mismatch_count == 0) begin
      $display("stepper_command_frame_driver_tb: clean");
    end else begin
      $display("stepper_command_frame_driver_tb: errors");
    end
    $finish;
  end

endmodule
